// ----- hdl/utf8d_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package utf8d_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned TDATA_W  = 24;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEAD = 2'd1,
		ST_MISSING  = 2'd2
	} status_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		status_t         status;
		logic            last;
	} result_t;

	// Results produced by one decoded byte: num_res is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] num_res;
		result_t    res0;
		result_t    res1;
	} dec_out_t;

endpackage

// ----- hdl/utf8_stream_decoder.sv -----
// Top level of the lenient UTF-8 stream decoder.
// Depends on utf8d_pkg, utf8d_decode and utf8d_queue.

// One byte enters per transfer on the slave side and 21-bit code points leave
// on the master side. The block takes one byte every clock cycle while the
// queue has room for two results: a byte is held in an input register,
// decoded by short logic against the open-sequence state, and its results are
// written into a four-entry result queue. m_tvalid rises once the queue holds
// a result. Most bytes give zero or
// one result, so a stream decodes at one byte per cycle as long as the sink
// keeps m_tready high. A byte that interrupts an open sequence with an ASCII
// character or an invalid lead gives two results (missing continuation, then
// the new result) and therefore needs two output transfers; the input stalls
// only when the queue lacks room for two results. m_tuser carries the status
// (0 code point, 1 invalid lead, 2 missing continuation), and m_tlast marks
// the final result caused by one input byte. Error results carry code point
// zero. No overlong or surrogate checks are made, and 0x00 is an ordinary
// code point.
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // last result of one input byte
);
	import utf8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              room;
	logic              advance;
	logic              s_fire;
	dec_out_t          dec;
	result_t           out_res;

	// Advance the held byte into the decoder when the queue can take two results.
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
		end
	end

	utf8d_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_s1),
		.fire      (advance),
		.dec       (dec)
	);

	utf8d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (dec),
		.push      (advance),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Zero-fill code point to whole bytes.
	assign m_tdata = {{(TDATA_W-CP_W){1'b0}}, out_res.code_point};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last;

endmodule

// ----- hdl/utf8d_decode.sv -----
// Byte decoder: sequence state registers and the per-byte decode logic.
// Depends on utf8d_pkg.
module utf8d_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [utf8d_pkg::BYTE_W-1:0]  data_byte,
	input  logic                          fire,
	output utf8d_pkg::dec_out_t           dec
);
	import utf8d_pkg::*;

	logic [1:0]      pending_q;
	logic [CP_W-1:0] partial_q;

	logic            lead_emit;
	result_t         lead_res;
	logic [1:0]      lead_pend;
	logic [CP_W-1:0] lead_partial;

	logic            is_cont;
	logic [1:0]      pend_dec;
	logic [CP_W-1:0] partial_shift;
	logic [1:0]      pend_d;
	logic [CP_W-1:0] partial_d;

	// Classify the byte as a fresh lead.
	always_comb begin
		lead_emit    = 1'b1;
		lead_pend    = 2'd0;
		lead_partial = '0;
		lead_res     = '{code_point: '0, status: ST_BAD_LEAD, last: 1'b1};
		if (data_byte[7] == 1'b0) begin
			lead_res.code_point = {{(CP_W-BYTE_W){1'b0}}, data_byte};
			lead_res.status     = ST_OK;
		end else if (data_byte[7:5] == 3'b110) begin
			lead_emit    = 1'b0;
			lead_pend    = 2'd1;
			lead_partial = {{(CP_W-5){1'b0}}, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_emit    = 1'b0;
			lead_pend    = 2'd2;
			lead_partial = {{(CP_W-4){1'b0}}, data_byte[3:0]};
		end else if (data_byte[7:3] == 5'b11110) begin
			lead_emit    = 1'b0;
			lead_pend    = 2'd3;
			lead_partial = {{(CP_W-3){1'b0}}, data_byte[2:0]};
		end
	end

	assign is_cont       = (data_byte[7:6] == 2'b10);
	assign pend_dec      = pending_q - 2'd1;
	assign partial_shift = {partial_q[CP_W-7:0], data_byte[5:0]};

	always_comb begin
		dec       = '0;
		pend_d    = pending_q;
		partial_d = partial_q;
		if (pending_q == 2'd0) begin
			dec.num_res = {1'b0, lead_emit};
			dec.res0    = lead_res;
			pend_d      = lead_pend;
			partial_d   = lead_partial;
		end else if (is_cont) begin
			pend_d    = pend_dec;
			partial_d = partial_shift;
			if (pend_dec == 2'd0) begin
				dec.num_res = 2'd1;
				dec.res0    = '{code_point: partial_shift, status: ST_OK, last: 1'b1};
				partial_d   = '0;
			end
		end else begin
			// Drop the open sequence, then decode this byte again as a lead.
			dec.res0    = '{code_point: '0, status: ST_MISSING, last: !lead_emit};
			dec.res1    = lead_res;
			dec.num_res = lead_emit ? 2'd2 : 2'd1;
			pend_d      = lead_pend;
			partial_d   = lead_partial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= '0;
		end else if (fire) begin
			pending_q <= pend_d;
			partial_q <= partial_d;
		end
	end

endmodule

// ----- hdl/utf8d_queue.sv -----
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on utf8d_pkg.
module utf8d_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8d_pkg::dec_out_t  dec,
	input  logic                 push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output utf8d_pkg::result_t   out_res
);
	import utf8d_pkg::*;

	result_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [QPTR_W-1:0]   wr_ptr_p1;
	logic [QCNT_W-1:0]   push_n;
	logic                pop;

	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign out_res   = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr_p1 = wr_ptr_q + QPTR_W'(1);
	assign push_n    = push ? QCNT_W'(dec.num_res) : '0;

	always_ff @(posedge clk) begin
		if (push && dec.num_res != 2'd0) begin
			entry_q[wr_ptr_q] <= dec.res0;
		end
		if (push && dec.num_res == 2'd2) begin
			entry_q[wr_ptr_p1] <= dec.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + push_n - QCNT_W'(pop);
		end
	end

endmodule

// ----- tb/tb_utf8_stream_decoder.sv -----
// Self-checking bench for utf8_stream_decoder: directed byte sequences, then random UTF-8 text.
// Needs utf8d_pkg and the decoder RTL; a class tracks the open sequence and the results it owes.
module tb_utf8_stream_decoder;
	import utf8d_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RANDOM_BYTES = 1200;
	localparam int CALM_BYTES   = 150;
	localparam int STALL_LIMIT  = 1000;
	localparam int SHOW_LIMIT   = 20;

	// Lead and continuation byte ranges.
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;
	localparam logic [7:0] LEAD2_LO  = 8'hC0;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF7;

	// Zero and DEL, stray continuations, 0xF8, 2/3/4-byte sequences (the largest
	// 21-bit value among them), an open sequence cut by ASCII, by 0xFF, by a new
	// multi-byte lead, and by a zero byte.
	localparam int OPENING_LEN = 23;
	localparam logic [7:0] OPENING [OPENING_LEN] = '{
		8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8,
		8'hC2, 8'hA9,
		8'hE2, 8'h82, 8'hAC,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'hE2, 8'h41,
		8'hC3, 8'hFF,
		8'hF0, 8'hC3, 8'hA9,
		8'hC2, 8'h00
	};

	class decode_tracker;
		logic [1:0]      cont_left;
		logic [CP_W-1:0] acc_bits;
		result_t         due_results[$];
		int              errors;
		int              n_bytes;
		int              n_results;
		int              n_status[3];

		function new();
			cont_left = '0;
			acc_bits  = '0;
			errors    = 0;
			n_bytes   = 0;
			n_results = 0;
			n_status  = '{0, 0, 0};
		endfunction

		function result_t make_result(logic [CP_W-1:0] cp, status_t st);
			result_t r;
			r.code_point = cp;
			r.status     = st;
			r.last       = 1'b0;
			return r;
		endfunction

		// Advance the decode state by one accepted byte and queue what it owes.
		function void note_byte(logic [7:0] b);
			result_t made[2];
			int      n;
			bit      as_lead;
			n       = 0;
			as_lead = 1'b1;
			n_bytes++;
			if (cont_left != 2'd0) begin
				if (b[7:6] == 2'b10) begin
					as_lead   = 1'b0;
					acc_bits  = {acc_bits[CP_W-7:0], b[5:0]};
					cont_left = cont_left - 2'd1;
					if (cont_left == 2'd0) begin
						made[n] = make_result(acc_bits, ST_OK);
						n++;
						acc_bits = '0;
					end
				end else begin
					// Drop the open sequence, then decode this byte as a fresh lead.
					made[n] = make_result('0, ST_MISSING);
					n++;
					cont_left = 2'd0;
					acc_bits  = '0;
				end
			end
			if (as_lead) begin
				if (b[7] == 1'b0) begin
					made[n] = make_result(CP_W'(b), ST_OK);
					n++;
				end else if (b[7:5] == 3'b110) begin
					cont_left = 2'd1;
					acc_bits  = CP_W'(b[4:0]);
				end else if (b[7:4] == 4'b1110) begin
					cont_left = 2'd2;
					acc_bits  = CP_W'(b[3:0]);
				end else if (b[7:3] == 5'b11110) begin
					cont_left = 2'd3;
					acc_bits  = CP_W'(b[2:0]);
				end else begin
					made[n] = make_result('0, ST_BAD_LEAD);
					n++;
				end
			end
			if (n > 0)
				made[n-1].last = 1'b1;
			for (int i = 0; i < n; i++)
				due_results.push_back(made[i]);
		endfunction

		function void flag_field(string field, logic [23:0] want, logic [23:0] got);
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		endfunction

		// Compare one output transfer against the oldest owed result.
		function void check_result(logic [TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
			result_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: unexpected result, expected none, actual tdata=%h tuser=%h tlast=%b",
						$time, tdata, tuser, tlast);
				return;
			end
			want = due_results.pop_front();
			n_results++;
			n_status[want.status]++;
			if (tdata !== {{(TDATA_W-CP_W){1'b0}}, want.code_point})
				flag_field("tdata", 24'(want.code_point), 24'(tdata));
			if (tuser !== want.status)
				flag_field("tuser", 24'(want.status), 24'(tuser));
			if (tlast !== want.last)
				flag_field("tlast", 24'(want.last), 24'(tlast));
		endfunction
	endclass

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	decode_tracker sb;
	bit            calm    = 1'b0;
	bit            tx_lazy = 1'b1;
	bit            rx_lazy = 1'b1;
	int            rx_hold = 0;

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	// Sink: drop m_tready in bursts while rx_lazy is set, with stretches of none.
	always @(negedge clk) begin
		if ($urandom_range(0, 49) == 0)
			rx_lazy = ~rx_lazy;
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (!calm && rx_lazy && $urandom_range(0, 7) == 0) begin
			rx_hold = $urandom_range(1, 13) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic push_byte(input logic [7:0] b);
		if ($urandom_range(0, 39) == 0)
			tx_lazy = ~tx_lazy;
		if (!calm && tx_lazy && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	// Hold the input until every owed result has left the block.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic push_sequence();
		int         len;
		int         n_cont;
		logic [7:0] lead;
		len = $urandom_range(1, 4);
		case (len)
			1: lead = 8'($urandom_range(0, ASCII_MAX));
			2: lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
			3: lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
			default: lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
		endcase
		n_cont = len - 1;
		// Cut some sequences short so the next lead finds them open.
		if (len > 1 && $urandom_range(0, 4) == 0)
			n_cont = $urandom_range(0, len - 2);
		push_byte(lead);
		repeat (n_cont)
			push_byte(8'($urandom_range(CONT_LO, CONT_HI)));
	endtask

	initial begin : stimulus
		int  stop_at;
		bit  paused;
		sb     = new();
		paused = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (OPENING[i])
			push_byte(OPENING[i]);
		drain_results();

		stop_at = sb.n_bytes + RANDOM_BYTES;
		while (sb.n_bytes < stop_at) begin
			if (!paused && sb.n_bytes >= stop_at - RANDOM_BYTES / 2) begin
				paused = 1'b1;
				drain_results();
			end
			if (sb.n_bytes >= stop_at - CALM_BYTES)
				calm = 1'b1;
			if ($urandom_range(0, 9) == 0)
				push_byte(8'($urandom));
			else
				push_sequence();
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Covered %0d input bytes and %0d results: %0d code points, %0d invalid leads,",
			sb.n_bytes, sb.n_results, sb.n_status[ST_OK], sb.n_status[ST_BAD_LEAD]);
		$display("%0d missing continuations, with random gaps and sink stalls.",
			sb.n_status[ST_MISSING]);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
